// ----- rtl/core/tbef_pkg.sv -----
// Shared types and constants for the touch/button event filter.
// No dependencies; imported by every module of the block.
package tbef_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int FIELD_W         = 16;
  localparam int KIND_W          = 3;
  localparam int WEIGHT_W        = 7;
  localparam int LIMIT_W         = 4;
  localparam int PATTERN_W       = 8;
  localparam int PEND_W          = 5;
  localparam int CFG_ADDR_W      = 2;
  localparam int CFG_DATA_W      = 16;
  localparam int IN_TDATA_W      = 56;
  localparam int OUT_TDATA_W     = 24;

  localparam logic [LIMIT_W-1:0]   LIMIT_RST   = 4'd3;
  localparam logic [WEIGHT_W-1:0]  WEIGHT_RST  = 7'd70;
  localparam logic [FIELD_W-1:0]   BASE_RST    = 16'd320;
  localparam logic [PATTERN_W-1:0] PATTERN_RST = 8'd253;

  localparam logic [WEIGHT_W-1:0]  PCT_FULL = 7'd100;
  localparam logic [PEND_W-1:0]    PEND_MAX = 5'd31;

  // x/100 == (x * DIV_MUL) >> DIV_SHIFT, exact for x < 2^23
  localparam int                   DIV_SHIFT = 30;
  localparam int                   DIV_MUL_W = 24;
  localparam logic [DIV_MUL_W-1:0] DIV_MUL   = 24'd10737419;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_DEBOUNCE = 2'd0,
    CFG_WEIGHT   = 2'd1,
    CFG_BASE     = 2'd2,
    CFG_PATTERN  = 2'd3
  } cfg_reg_t;

  typedef enum logic [KIND_W-1:0] {
    EV_GO    = 3'd0,
    EV_POWER = 3'd1,
    EV_TOUCH = 3'd2,
    EV_ABS_X = 3'd3,
    EV_ABS_Y = 3'd4
  } ev_kind_t;

  typedef struct packed {
    logic go_ev;
    logic go_val;
    logic pwr_ev;
    logic pwr_val;
    logic abs_ev;
    logic abs_sync;
    logic tch_ev;
    logic tch_val;
  } ev_flags_t;

endpackage

// ----- rtl/core/tbef_decide.sv -----
// Input register, key/touch state and debounce decision; forms weighted sums
// for the coordinate filter. Depends on tbef_pkg.
module tbef_decide import tbef_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            buttons_ok,
  input  logic [7:0]                      button_byte0,
  input  logic [7:0]                      button_byte1,
  input  logic                            touch_ok,
  input  logic [FIELD_W-1:0]              raw_x,
  input  logic [FIELD_W-1:0]              raw_y,
  input  logic [LIMIT_W-1:0]              debounce_limit,
  input  logic [WEIGHT_W-1:0]             old_weight,
  input  logic [FIELD_W-1:0]              mirror_base,
  input  logic [PATTERN_W-1:0]            power_pattern,
  input  logic [COORD_WIDTH-1:0]          filt_x,
  input  logic [COORD_WIDTH-1:0]          filt_y,
  input  logic                            filt_busy,
  output logic                            dn_valid,
  input  logic                            dn_ready,
  output ev_flags_t                       dn_flags,
  output logic [COORD_WIDTH+WEIGHT_W-1:0] dn_sum_x,
  output logic [COORD_WIDTH+WEIGHT_W-1:0] dn_sum_y
);

  localparam int SUM_W = COORD_WIDTH + WEIGHT_W;

  logic                   s1_v_r;
  logic                   bok_r;
  logic [7:0]             b0_r;
  logic [7:0]             b1_r;
  logic                   tok_r;
  logic [FIELD_W-1:0]     rx_r;
  logic [FIELD_W-1:0]     ry_r;

  logic                   go_st_r;
  logic                   pwr_st_r;
  logic                   tch_st_r;
  logic [PEND_W-1:0]      pend_r;
  logic [PEND_W-1:0]      pend_nxt;

  logic                   go;
  logic                   pwr;
  logic [COORD_WIDTH-1:0] x;
  logic [COORD_WIDTH-1:0] y;
  logic                   touch;
  logic                   differ;
  logic                   take;
  logic                   tch_on;
  logic [PEND_W-1:0]      pend_inc;
  logic [PEND_W-1:0]      pend1;
  logic [WEIGHT_W-1:0]    w_clamp;
  logic [WEIGHT_W-1:0]    w_eff;
  logic [WEIGHT_W-1:0]    w_new;
  logic                   s1_move;

  assign go     = b0_r[0];
  assign pwr    = (b1_r == power_pattern);
  assign x      = mirror_base[COORD_WIDTH-1:0] - rx_r[COORD_WIDTH-1:0];
  assign y      = ry_r[COORD_WIDTH-1:0];
  assign touch  = (x > COORD_WIDTH'(1)) && (y > COORD_WIDTH'(1));
  assign differ = (touch != tch_st_r);
  assign tch_on = bok_r & tok_r;

  assign pend_inc = (pend_r == PEND_MAX) ? pend_r : pend_r + PEND_W'(1);
  assign pend1    = differ ? pend_inc : '0;
  assign take     = !touch || (pend1 > {1'b0, debounce_limit});

  assign dn_flags.go_ev    = bok_r & (go != go_st_r);
  assign dn_flags.go_val   = go;
  assign dn_flags.pwr_ev   = bok_r & (pwr != pwr_st_r);
  assign dn_flags.pwr_val  = pwr;
  assign dn_flags.abs_ev   = tch_on & ((take & touch) | (!take & tch_st_r));
  assign dn_flags.abs_sync = tch_on & !take & tch_st_r;
  assign dn_flags.tch_ev   = tch_on & take & differ;
  assign dn_flags.tch_val  = touch;

  assign pend_nxt = dn_flags.tch_ev ? '0 : pend1;

  // press: weight 0 so the divider returns the raw coordinate
  assign w_clamp = (old_weight > PCT_FULL) ? PCT_FULL : old_weight;
  assign w_eff   = take ? '0 : w_clamp;
  assign w_new   = PCT_FULL - w_eff;

  assign dn_sum_x = SUM_W'(filt_x) * SUM_W'(w_eff) + SUM_W'(x) * SUM_W'(w_new);
  assign dn_sum_y = SUM_W'(filt_y) * SUM_W'(w_eff) + SUM_W'(y) * SUM_W'(w_new);

  assign dn_valid = s1_v_r & !filt_busy;
  assign s1_move  = s1_v_r & dn_ready & !filt_busy;
  assign in_ready = !s1_v_r | s1_move;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r   <= 1'b0;
      go_st_r  <= 1'b0;
      pwr_st_r <= 1'b0;
      tch_st_r <= 1'b0;
      pend_r   <= '0;
    end else begin
      if (in_ready) begin
        s1_v_r <= in_valid;
      end
      if (s1_move && bok_r) begin
        go_st_r  <= go;
        pwr_st_r <= pwr;
        if (tok_r) begin
          pend_r <= pend_nxt;
          if (dn_flags.tch_ev) begin
            tch_st_r <= touch;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      bok_r <= buttons_ok;
      b0_r  <= button_byte0;
      b1_r  <= button_byte1;
      tok_r <= touch_ok;
      rx_r  <= raw_x;
      ry_r  <= raw_y;
    end
  end

endmodule

// ----- rtl/core/tbef_scale.sv -----
// Divide-by-100 stage of the coordinate filter and the filtered coordinate
// state. Depends on tbef_pkg.
module tbef_scale import tbef_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            up_valid,
  output logic                            up_ready,
  input  ev_flags_t                       up_flags,
  input  logic [COORD_WIDTH+WEIGHT_W-1:0] up_sum_x,
  input  logic [COORD_WIDTH+WEIGHT_W-1:0] up_sum_y,
  output logic [COORD_WIDTH-1:0]          filt_x,
  output logic [COORD_WIDTH-1:0]          filt_y,
  output logic                            filt_busy,
  output logic                            dn_valid,
  input  logic                            dn_ready,
  output ev_flags_t                       dn_flags,
  output logic [COORD_WIDTH-1:0]          dn_x,
  output logic [COORD_WIDTH-1:0]          dn_y
);

  localparam int SUM_W  = COORD_WIDTH + WEIGHT_W;
  localparam int PROD_W = SUM_W + DIV_MUL_W;

  logic                   s2_v_r;
  ev_flags_t              flags_r;
  logic [SUM_W-1:0]       sum_x_r;
  logic [SUM_W-1:0]       sum_y_r;
  logic [COORD_WIDTH-1:0] filt_x_r;
  logic [COORD_WIDTH-1:0] filt_y_r;

  logic [PROD_W-1:0]      prod_x;
  logic [PROD_W-1:0]      prod_y;
  logic                   has_ev;
  logic                   move;

  assign prod_x = PROD_W'(sum_x_r) * PROD_W'(DIV_MUL);
  assign prod_y = PROD_W'(sum_y_r) * PROD_W'(DIV_MUL);
  assign dn_x   = prod_x[DIV_SHIFT +: COORD_WIDTH];
  assign dn_y   = prod_y[DIV_SHIFT +: COORD_WIDTH];

  assign has_ev    = flags_r.go_ev | flags_r.pwr_ev | flags_r.abs_ev | flags_r.tch_ev;
  assign dn_valid  = s2_v_r & has_ev;
  assign dn_flags  = flags_r;
  assign move      = s2_v_r & (!has_ev | dn_ready);
  assign up_ready  = !s2_v_r | move;
  assign filt_busy = s2_v_r & flags_r.abs_ev;
  assign filt_x    = filt_x_r;
  assign filt_y    = filt_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r   <= 1'b0;
      filt_x_r <= '0;
      filt_y_r <= '0;
    end else begin
      if (up_ready) begin
        s2_v_r <= up_valid;
      end
      if (move && flags_r.abs_ev) begin
        filt_x_r <= dn_x;
        filt_y_r <= dn_y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      flags_r <= up_flags;
      sum_x_r <= up_sum_x;
      sum_y_r <= up_sum_y;
    end
  end

endmodule

// ----- rtl/core/tbef_emit.sv -----
// Event sequencer: holds one sample's pending events and sends them one beat
// per cycle through the output register while out_ready is high. Depends on tbef_pkg.
module tbef_emit import tbef_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   up_valid,
  output logic                   up_ready,
  input  ev_flags_t              up_flags,
  input  logic [COORD_WIDTH-1:0] up_x,
  input  logic [COORD_WIDTH-1:0] up_y,
  output logic                   out_valid,
  input  logic                   out_ready,
  output ev_kind_t               out_kind,
  output logic [FIELD_W-1:0]     out_value,
  output logic                   out_sync,
  output logic                   out_last
);

  // mask bits in send order: go, power, abs x, abs y, touch
  logic [4:0]             mask_r;
  logic [4:0]             mask_nxt;
  logic                   go_val_r;
  logic                   pwr_val_r;
  logic                   tch_val_r;
  logic                   abs_sync_r;
  logic [COORD_WIDTH-1:0] x_r;
  logic [COORD_WIDTH-1:0] y_r;

  logic                   out_v_r;
  ev_kind_t               kind_r;
  logic [FIELD_W-1:0]     value_r;
  logic                   sync_r;
  logic                   last_r;

  logic [4:0]             pick;
  logic [4:0]             rest;
  ev_kind_t               pick_kind;
  logic [FIELD_W-1:0]     pick_value;
  logic                   pick_sync;
  logic                   out_adv;
  logic                   up_take;
  logic [4:0]             up_mask;

  always_comb begin
    pick       = '0;
    pick_kind  = EV_GO;
    pick_value = '0;
    pick_sync  = 1'b1;
    if (mask_r[0]) begin
      pick       = 5'b00001;
      pick_value = FIELD_W'(go_val_r);
    end else if (mask_r[1]) begin
      pick       = 5'b00010;
      pick_kind  = EV_POWER;
      pick_value = FIELD_W'(pwr_val_r);
    end else if (mask_r[2]) begin
      pick       = 5'b00100;
      pick_kind  = EV_ABS_X;
      pick_value = FIELD_W'(x_r);
      pick_sync  = 1'b0;
    end else if (mask_r[3]) begin
      pick       = 5'b01000;
      pick_kind  = EV_ABS_Y;
      pick_value = FIELD_W'(y_r);
      pick_sync  = abs_sync_r;
    end else if (mask_r[4]) begin
      pick       = 5'b10000;
      pick_kind  = EV_TOUCH;
      pick_value = FIELD_W'(tch_val_r);
    end
  end

  assign rest     = mask_r & ~pick;
  assign out_adv  = !out_v_r | out_ready;
  assign up_ready = (mask_r == '0) | (out_adv & (rest == '0));
  assign up_take  = up_valid & up_ready;
  assign up_mask  = {up_flags.tch_ev, up_flags.abs_ev, up_flags.abs_ev,
                     up_flags.pwr_ev, up_flags.go_ev};

  always_comb begin
    mask_nxt = mask_r;
    if (up_take) begin
      mask_nxt = up_mask;
    end else if (out_adv) begin
      mask_nxt = rest;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r  <= '0;
      out_v_r <= 1'b0;
    end else begin
      mask_r <= mask_nxt;
      if (out_adv) begin
        out_v_r <= |mask_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (up_take) begin
      go_val_r   <= up_flags.go_val;
      pwr_val_r  <= up_flags.pwr_val;
      tch_val_r  <= up_flags.tch_val;
      abs_sync_r <= up_flags.abs_sync;
      x_r        <= up_x;
      y_r        <= up_y;
    end
    if (out_adv && (mask_r != '0)) begin
      kind_r  <= pick_kind;
      value_r <= pick_value;
      sync_r  <= pick_sync;
      last_r  <= (rest == '0);
    end
  end

  assign out_valid = out_v_r;
  assign out_kind  = kind_r;
  assign out_value = value_r;
  assign out_sync  = sync_r;
  assign out_last  = last_r;

endmodule

// ----- rtl/core/touch_button_event_filter.sv -----
// Touch/button event filter: one poll sample per beat in, 0..5 events out.
// The first event of a sample passes the input, scale, event mask and output registers.
// Throughput: one sample per cycle, bounded by one event beat per cycle on the
// output and by out_tready; a sample that updates the coordinate filter holds
// the next sample while the filtered value is written back.
// Reset (synchronous, rst_n low): key/touch state, filter and config to defaults.
module touch_button_event_filter import tbef_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [0] buttons_ok, [8:1] button_byte0, [16:9] button_byte1, [17] touch_ok,
  // [33:18] raw_x, [49:34] raw_y
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [15:0] event_value, [16] sync_after
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // [2:0] event_kind
  output logic [KIND_W-1:0]      out_tuser,
  output logic                   out_tlast,
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int SUM_W = COORD_WIDTH + WEIGHT_W;

  logic [LIMIT_W-1:0]     limit_r;
  logic [WEIGHT_W-1:0]    weight_r;
  logic [FIELD_W-1:0]     base_r;
  logic [PATTERN_W-1:0]   pattern_r;

  logic                   d_valid;
  logic                   d_ready;
  ev_flags_t              d_flags;
  logic [SUM_W-1:0]       d_sum_x;
  logic [SUM_W-1:0]       d_sum_y;
  logic [COORD_WIDTH-1:0] filt_x;
  logic [COORD_WIDTH-1:0] filt_y;
  logic                   filt_busy;

  logic                   s_valid;
  logic                   s_ready;
  ev_flags_t              s_flags;
  logic [COORD_WIDTH-1:0] s_x;
  logic [COORD_WIDTH-1:0] s_y;

  ev_kind_t               ev_kind;
  logic [FIELD_W-1:0]     ev_value;
  logic                   ev_sync;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r   <= LIMIT_RST;
      weight_r  <= WEIGHT_RST;
      base_r    <= BASE_RST;
      pattern_r <= PATTERN_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        CFG_DEBOUNCE: limit_r   <= cfg_wdata[LIMIT_W-1:0];
        CFG_WEIGHT:   weight_r  <= cfg_wdata[WEIGHT_W-1:0];
        CFG_BASE:     base_r    <= cfg_wdata[FIELD_W-1:0];
        CFG_PATTERN:  pattern_r <= cfg_wdata[PATTERN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  tbef_decide #(.COORD_WIDTH(COORD_WIDTH)) u_decide (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_tvalid),
    .in_ready       (in_tready),
    .buttons_ok     (in_tdata[0]),
    .button_byte0   (in_tdata[8:1]),
    .button_byte1   (in_tdata[16:9]),
    .touch_ok       (in_tdata[17]),
    .raw_x          (in_tdata[33:18]),
    .raw_y          (in_tdata[49:34]),
    .debounce_limit (limit_r),
    .old_weight     (weight_r),
    .mirror_base    (base_r),
    .power_pattern  (pattern_r),
    .filt_x         (filt_x),
    .filt_y         (filt_y),
    .filt_busy      (filt_busy),
    .dn_valid       (d_valid),
    .dn_ready       (d_ready),
    .dn_flags       (d_flags),
    .dn_sum_x       (d_sum_x),
    .dn_sum_y       (d_sum_y)
  );

  tbef_scale #(.COORD_WIDTH(COORD_WIDTH)) u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (d_valid),
    .up_ready  (d_ready),
    .up_flags  (d_flags),
    .up_sum_x  (d_sum_x),
    .up_sum_y  (d_sum_y),
    .filt_x    (filt_x),
    .filt_y    (filt_y),
    .filt_busy (filt_busy),
    .dn_valid  (s_valid),
    .dn_ready  (s_ready),
    .dn_flags  (s_flags),
    .dn_x      (s_x),
    .dn_y      (s_y)
  );

  tbef_emit #(.COORD_WIDTH(COORD_WIDTH)) u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (s_valid),
    .up_ready  (s_ready),
    .up_flags  (s_flags),
    .up_x      (s_x),
    .up_y      (s_y),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_kind  (ev_kind),
    .out_value (ev_value),
    .out_sync  (ev_sync),
    .out_last  (out_tlast)
  );

  assign out_tdata = {(OUT_TDATA_W - FIELD_W - 1)'(0), ev_sync, ev_value};
  assign out_tuser = ev_kind;

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  a_key_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == EV_GO || out_tuser == EV_POWER || out_tuser == EV_TOUCH)
    |-> out_tdata[16] && (out_tdata[15:1] == '0))
    else $error("key event without sync or with a non-binary value");

  a_abs_x: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == EV_ABS_X) |-> !out_tdata[16] && !out_tlast)
    else $error("abs x event marked sync or last");

endmodule

// ----- tb/touch_button_event_filter_test.sv -----
`timescale 1ns / 100ps
// Testbench for touch_button_event_filter: a directed poll table, then random
// finger/button sequences under several register settings, each event beat
// checked against dir_exp or an in-bench filter model. Needs tbef_pkg and the RTL.
module touch_button_event_filter_test;
  import tbef_pkg::*;

  typedef struct packed {
    logic                 buttons_ok;
    logic [7:0]           byte0;
    logic [7:0]           byte1;
    logic                 touch_ok;
    logic [FIELD_W-1:0]   raw_x;
    logic [FIELD_W-1:0]   raw_y;
  } poll_t;

  typedef struct packed {
    ev_kind_t             kind;
    logic [FIELD_W-1:0]   value;
    logic                 sync;
    logic                 last;
  } touch_event_t;

  // n_exp: count of hand-written events in dir_exp, or BY_MODEL
  typedef struct packed {
    poll_t                poll;
    logic signed [3:0]    n_exp;
  } dir_row_t;

  localparam logic signed [3:0] BY_MODEL = -4'sd1;
  localparam int PHASES       = 6;
  localparam int PHASE_POLLS  = 65;
  localparam int DRAIN_CYCLES = 16;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [KIND_W-1:0]      out_tuser;
  logic                   out_tlast;
  logic                   cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr = CFG_DEBOUNCE;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  // filter model state and register copies
  logic                   go_q, pwr_q, touch_q;
  logic [PEND_W-1:0]      pend_cnt;
  logic [FIELD_W-1:0]     filt_x, filt_y;
  logic [LIMIT_W-1:0]     lim_r;
  logic [WEIGHT_W-1:0]    weight_r;
  logic [FIELD_W-1:0]     base_r;
  logic [PATTERN_W-1:0]   pattern_r;

  touch_event_t           poll_events[$];
  touch_event_t           due_events[$];
  int                     errors = 0;
  int                     typed_at = 0;
  int                     stall_left = 0;
  bit                     idle_on = 1'b1;

  // random finger and key generator state
  bit                     finger_down = 1'b0;
  int                     hold_left = 0;
  logic [FIELD_W-1:0]     fx, fy;
  bit                     go_key = 1'b0;
  bit                     pwr_key = 1'b0;

  // reset registers: limit 3, weight 70, base 320, pattern 253
  dir_row_t dir_rows [21] = '{
    '{'{1'b0, 8'hFF, 8'hFF,  1'b1, 16'hFFFF, 16'hFFFF}, 4'sd0},  // ignored poll
    '{'{1'b1, 8'h01, 8'h00,  1'b0, 16'h0000, 16'h0000}, 4'sd1},
    '{'{1'b1, 8'hFE, 8'd253, 1'b0, 16'h0000, 16'h0000}, 4'sd2},
    '{'{1'b1, 8'h00, 8'h00,  1'b1, 16'd320,  16'd0},    4'sd1},  // x = 0
    '{'{1'b1, 8'h00, 8'h00,  1'b1, 16'd20,   16'd100},  4'sd0},  // press pending
    '{'{1'b1, 8'h00, 8'h00,  1'b1, 16'd20,   16'd100},  4'sd0},
    '{'{1'b1, 8'h00, 8'h00,  1'b1, 16'd20,   16'd100},  4'sd0},
    '{'{1'b1, 8'h00, 8'h00,  1'b1, 16'd20,   16'd100},  BY_MODEL},
    '{'{1'b1, 8'h00, 8'h00,  1'b1, 16'd0,    16'd200},  BY_MODEL},
    '{'{1'b1, 8'h00, 8'h00,  1'b1, 16'hFFFF, 16'hFFFF}, BY_MODEL},
    '{'{1'b1, 8'h00, 8'h00,  1'b1, 16'd319,  16'd500},  4'sd1},  // x = 1: release
    '{'{1'b1, 8'hFF, 8'hFF,  1'b0, 16'hFFFF, 16'hFFFF}, 4'sd1},
    '{'{1'b1, 8'hFF, 8'h00,  1'b1, 16'd318,  16'd2},    4'sd0},  // x = y = 2
    '{'{1'b1, 8'hFF, 8'h00,  1'b1, 16'd318,  16'd1},    4'sd0},  // bounce clears count
    '{'{1'b1, 8'hFF, 8'h00,  1'b1, 16'd318,  16'd2},    4'sd0},
    '{'{1'b1, 8'hFF, 8'h00,  1'b1, 16'd318,  16'd2},    4'sd0},
    '{'{1'b1, 8'hFF, 8'h00,  1'b1, 16'd318,  16'd2},    4'sd0},
    '{'{1'b1, 8'hFF, 8'h00,  1'b1, 16'd318,  16'd2},    BY_MODEL},
    '{'{1'b1, 8'h01, 8'd253, 1'b1, 16'd318,  16'd2},    BY_MODEL},
    '{'{1'b1, 8'h01, 8'd253, 1'b1, 16'd321,  16'd0},    4'sd1},  // x wraps, y = 0
    '{'{1'b0, 8'h00, 8'h00,  1'b0, 16'h0000, 16'h0000}, 4'sd0}
  };

  touch_event_t dir_exp [7] = '{
    '{EV_GO,    16'd1, 1'b1, 1'b1},
    '{EV_GO,    16'd0, 1'b1, 1'b0},
    '{EV_POWER, 16'd1, 1'b1, 1'b1},
    '{EV_POWER, 16'd0, 1'b1, 1'b1},
    '{EV_TOUCH, 16'd0, 1'b1, 1'b1},
    '{EV_GO,    16'd1, 1'b1, 1'b1},
    '{EV_TOUCH, 16'd0, 1'b1, 1'b1}
  };

  cfg_reg_t reg_order [4] = '{CFG_DEBOUNCE, CFG_WEIGHT, CFG_BASE, CFG_PATTERN};

  touch_button_event_filter u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #(20_000_000);
    $display("*** FAILED ***");
    $finish;
  end

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= 40) $display("ERROR %0t ns: %s", $time, what);
  endtask

  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic void add_event(input ev_kind_t k, input logic [FIELD_W-1:0] v,
                                    input logic s);
    touch_event_t e;
    e.kind  = k;
    e.value = v;
    e.sync  = s;
    e.last  = 1'b0;
    poll_events.push_back(e);
  endfunction

  function automatic logic [FIELD_W-1:0] smooth_coord(input logic [FIELD_W-1:0] prev,
                                                      input logic [FIELD_W-1:0] fresh,
                                                      input int unsigned w);
    int unsigned acc;
    acc = prev * w + fresh * (100 - w);
    return FIELD_W'(acc / 100);
  endfunction

  function automatic void derive_events(input poll_t p);
    logic               go, pwr, touch;
    logic [FIELD_W-1:0] x, y;
    int unsigned        w;
    poll_events.delete();
    if (!p.buttons_ok) return;
    go  = p.byte0[0];
    pwr = (p.byte1 == pattern_r);
    if (go != go_q) begin
      add_event(EV_GO, {15'd0, go}, 1'b1);
      go_q = go;
    end
    if (pwr != pwr_q) begin
      add_event(EV_POWER, {15'd0, pwr}, 1'b1);
      pwr_q = pwr;
    end
    if (p.touch_ok) begin
      x = base_r - p.raw_x;
      y = p.raw_y;
      touch = (x > 1) && (y > 1);
      if (touch != touch_q) begin
        if (pend_cnt < PEND_MAX) pend_cnt = pend_cnt + 1'b1;
      end else begin
        pend_cnt = '0;
      end
      if (!touch || pend_cnt > lim_r) begin
        if (touch) begin
          filt_x = x;
          filt_y = y;
          add_event(EV_ABS_X, x, 1'b0);
          add_event(EV_ABS_Y, y, 1'b0);
        end
        if (touch != touch_q) begin
          add_event(EV_TOUCH, {15'd0, touch}, 1'b1);
          pend_cnt = '0;
          touch_q  = touch;
        end
      end else if (touch_q) begin
        w = (weight_r > PCT_FULL) ? 100 : weight_r;
        filt_x = smooth_coord(filt_x, x, w);
        filt_y = smooth_coord(filt_y, y, w);
        add_event(EV_ABS_X, filt_x, 1'b0);
        add_event(EV_ABS_Y, filt_y, 1'b1);
      end
    end
    if (poll_events.size() > 0) poll_events[poll_events.size() - 1].last = 1'b1;
  endfunction

  // mostly held or lifted finger runs with jitter, some glitches and junk
  function automatic void gen_poll(output poll_t p);
    logic [FIELD_W-1:0] x, y;
    if (hold_left == 0) begin
      finger_down = !finger_down;
      hold_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) == 0) begin
        fx = FIELD_W'($urandom_range(2, 400));
        fy = FIELD_W'($urandom_range(2, 400));
      end else begin
        fx = FIELD_W'($urandom_range(2, 65527));
        fy = FIELD_W'($urandom_range(2, 65527));
      end
    end
    hold_left--;
    if ($urandom_range(0, 5) == 0) go_key = !go_key;
    if ($urandom_range(0, 5) == 0) pwr_key = !pwr_key;
    p.buttons_ok = ($urandom_range(0, 19) != 0);
    p.byte0 = {7'($urandom), go_key};
    p.byte1 = pwr_key ? pattern_r : 8'($urandom);
    p.touch_ok = ($urandom_range(0, 9) != 0);
    case ($urandom_range(0, 19))
      0: begin
        x = FIELD_W'($urandom);
        y = FIELD_W'($urandom);
      end
      1: begin
        x = FIELD_W'($urandom_range(0, 1));
        y = FIELD_W'($urandom);
      end
      default: begin
        if (finger_down) begin
          x = fx + FIELD_W'($urandom_range(0, 8));
          y = fy + FIELD_W'($urandom_range(0, 8));
        end else if ($urandom_range(0, 1) == 1) begin
          x = FIELD_W'($urandom);
          y = FIELD_W'($urandom_range(0, 1));
        end else begin
          x = FIELD_W'($urandom_range(0, 1));
          y = FIELD_W'($urandom);
        end
      end
    endcase
    p.raw_x = base_r - x;
    p.raw_y = y;
  endfunction

  task automatic send_poll(input poll_t p, input logic signed [3:0] n_exp);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= {6'd0, p.raw_y, p.raw_x, p.touch_ok, p.byte1, p.byte0, p.buttons_ok};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    derive_events(p);
    if (n_exp == BY_MODEL) begin
      foreach (poll_events[k]) due_events.push_back(poll_events[k]);
    end else begin
      for (int k = 0; k < n_exp; k++) due_events.push_back(dir_exp[typed_at++]);
    end
  endtask

  task automatic settle(input bit hold);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (due_events.size() != 0) @(posedge clk);
    if (hold) repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [CFG_DATA_W-1:0] lim, input logic [CFG_DATA_W-1:0] w,
                            input logic [CFG_DATA_W-1:0] base,
                            input logic [CFG_DATA_W-1:0] pat);
    foreach (reg_order[i]) begin
      cfg_we   <= 1'b1;
      cfg_addr <= reg_order[i];
      case (reg_order[i])
        CFG_DEBOUNCE: begin
          cfg_wdata <= lim;
          lim_r = lim[LIMIT_W-1:0];
        end
        CFG_WEIGHT: begin
          cfg_wdata <= w;
          weight_r = w[WEIGHT_W-1:0];
        end
        CFG_BASE: begin
          cfg_wdata <= base;
          base_r = base;
        end
        default: begin
          cfg_wdata <= pat;
          pattern_r = pat[PATTERN_W-1:0];
        end
      endcase
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk) begin
    touch_event_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (due_events.size() == 0) begin
        report_mismatch($sformatf("unexpected beat kind %0d value %0d",
                                  out_tuser, out_tdata[FIELD_W-1:0]));
      end else begin
        want = due_events.pop_front();
        if (out_tuser != want.kind || out_tdata[FIELD_W-1:0] != want.value ||
            out_tdata[FIELD_W] != want.sync || out_tlast != want.last) begin
          report_mismatch($sformatf(
            "kind/value/sync/last got %0d/%0d/%0b/%0b want %0d/%0d/%0b/%0b",
            out_tuser, out_tdata[FIELD_W-1:0], out_tdata[FIELD_W], out_tlast,
            want.kind, want.value, want.sync, want.last));
        end
      end
    end
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else begin
      out_tready <= 1'b1;
      stall_left = pick_gap();
    end
  end

  initial begin
    poll_t p;
    int    cnt;
    bit    paused;
    lim_r     = LIMIT_RST;
    weight_r  = WEIGHT_RST;
    base_r    = BASE_RST;
    pattern_r = PATTERN_RST;
    go_q      = 1'b0;
    pwr_q     = 1'b0;
    touch_q   = 1'b0;
    pend_cnt  = '0;
    filt_x    = '0;
    filt_y    = '0;
    paused    = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) send_poll(dir_rows[i].poll, dir_rows[i].n_exp);

    for (int ph = 1; ph <= PHASES; ph++) begin
      settle(1'b1);
      idle_on = (ph != 3);
      case (ph)
        1: set_config(16'd0, 16'd0, 16'h0000, 16'd0);
        2: set_config(16'd15, 16'd100, 16'hFFFF, 16'd255);
        3: set_config(16'($urandom_range(0, 15)), 16'd127,
                      16'($urandom_range(0, 65535)), 16'($urandom_range(0, 255)));
        default: set_config(16'($urandom_range(0, 15)), 16'($urandom_range(0, 127)),
                            16'($urandom_range(0, 65535)), 16'($urandom_range(0, 255)));
      endcase
      cnt = 0;
      while (cnt < PHASE_POLLS) begin
        if (ph == 4 && cnt == 30 && !paused) begin
          paused = 1'b1;
          settle(1'b0);
        end
        gen_poll(p);
        send_poll(p, BY_MODEL);
        if (p.buttons_ok) cnt++;
      end
    end

    settle(1'b1);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
